/* hdl/spb_pkg.sv */
// Shared types and constants for the send buffer packer.
// Used by every module of the block; no dependencies of its own.
package spb_pkg;

  localparam int DEF_BLOCK_QWORDS = 8;
  localparam int DEF_ADDR_BITS    = 16;
  localparam int DEF_QUEUE_DEPTH  = 4;

  localparam int QW_BITS   = 16;
  localparam int SIZE_BITS = 17;
  localparam int DATA_BITS = 64;
  localparam int CFG_BITS  = 17;

  localparam logic [SIZE_BITS-1:0] RING_SIZE_RESET = 17'd8;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2
  } opcode_t;

  typedef enum logic {
    REG_RING_BASE = 1'b0,
    REG_RING_SIZE = 1'b1
  } reg_index_t;

  // One run of writes: qword indexes q_first..q_last of the packet, the first
  // carrying data, the rest zero.
  typedef struct packed {
    logic [QW_BITS-1:0]   pstart;
    logic [QW_BITS-1:0]   q_first;
    logic [QW_BITS-1:0]   q_last;
    logic [DATA_BITS-1:0] data;
  } cmd_t;

endpackage

/* hdl/pio_send_buffer_packer.sv */
// Top level of the send buffer packer: configuration registers, front end,
// command queue and back end. Depends on spb_pkg, spb_front, spb_queue, spb_back.
//
//  channel   direction  handshake            payload
//  input     in         in_valid/in_stall    opcode, data_word, start_qw
//  output    out        out_valid/out_stall  write_addr, in_sop, write_data, last
//  config    in         cfg_we               cfg_index, cfg_data
//
// The front end takes one word a cycle while the queue has room; with the back end idle
// the first write of an item passes the queue, the back end's command register
// and the output register. Start and paired data words give one write; an end word
// gives up to BLOCK_QWORDS writes from the back-end walker, one a cycle unless stalled.
// rst (synchronous) empties the queue and output register and clears packet state.
// Output stall holds the output register; the queue then fills and raises in_stall.
module pio_send_buffer_packer #(
  parameter int BLOCK_QWORDS = spb_pkg::DEF_BLOCK_QWORDS,
  parameter int ADDR_BITS    = spb_pkg::DEF_ADDR_BITS,
  parameter int QUEUE_DEPTH  = spb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [spb_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [spb_pkg::DATA_BITS-1:0] data_word,
  input  logic [spb_pkg::QW_BITS-1:0]   start_qw,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spb_pkg::QW_BITS-1:0]   write_addr,
  output logic                          in_sop,
  output logic [spb_pkg::DATA_BITS-1:0] write_data,
  output logic                          last
);
  import spb_pkg::*;

  logic [QW_BITS-1:0]   ring_base;
  logic [SIZE_BITS-1:0] ring_size;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  cmd_t head;
  logic head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base <= '0;
      ring_size <= RING_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RING_BASE: ring_base <= cfg_data[QW_BITS-1:0];
        REG_RING_SIZE: ring_size <= cfg_data[SIZE_BITS-1:0];
        default:       ring_base <= ring_base;
      endcase
    end
  end

  spb_front #(
    .BLOCK_QWORDS(BLOCK_QWORDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .data_word (data_word),
    .start_qw  (start_qw),
    .push      (push),
    .push_cmd  (push_cmd),
    .queue_full(queue_full)
  );

  spb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  spb_back #(
    .BLOCK_QWORDS(BLOCK_QWORDS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .ring_base (ring_base),
    .ring_size (ring_size),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .write_addr(write_addr),
    .in_sop    (in_sop),
    .write_data(write_data),
    .last      (last)
  );

endmodule

/* hdl/spb_queue.sv */
// Small flop-based command queue between the front and back ends.
// Depends on spb_pkg for the command type.
module spb_queue #(
  parameter int DEPTH = spb_pkg::DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  spb_pkg::cmd_t push_cmd,
  output logic         full,
  input  logic         pop,
  output spb_pkg::cmd_t head,
  output logic         head_valid
);
  import spb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/spb_front.sv */
// Front end: accepts input words, pairs dwords, tracks the packet position
// and turns each item into at most one write command. Depends on spb_pkg.
module spb_front #(
  parameter int BLOCK_QWORDS = spb_pkg::DEF_BLOCK_QWORDS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [spb_pkg::DATA_BITS-1:0] data_word,
  input  logic [spb_pkg::QW_BITS-1:0]   start_qw,
  output logic                          push,
  output spb_pkg::cmd_t                 push_cmd,
  input  logic                          queue_full
);
  import spb_pkg::*;

  localparam int OFF_W = $clog2(BLOCK_QWORDS);

  logic [QW_BITS-1:0] pstart, pstart_next;
  logic [QW_BITS-1:0] ww, ww_next;
  logic [OFF_W-1:0]   off, off_next;
  logic [31:0]        held, held_next;
  logic               hv, hv_next;

  logic               accept;
  logic [OFF_W-1:0]   off_inc;
  logic [QW_BITS-1:0] ww1;
  logic [OFF_W-1:0]   off1;
  logic [16:0]        to_blk;
  logic [16:0]        to_wrap;
  logic [16:0]        pad;
  logic [QW_BITS-1:0] ww_end;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  // Block offset of words_written; the counter wrapping to zero restarts it.
  assign off_inc = (ww == {QW_BITS{1'b1}} || off == OFF_W'(BLOCK_QWORDS - 1)) ?
                   '0 : off + 1'b1;

  // End: flush the held dword, then pad to the block edge or counter wrap.
  assign ww1     = hv ? ww + 1'b1 : ww;
  assign off1    = hv ? off_inc : off;
  assign to_blk  = 17'(BLOCK_QWORDS) - 17'(off1);
  assign to_wrap = 17'h10000 - {1'b0, ww1};
  assign pad     = (off1 == '0) ? '0 : ((to_blk < to_wrap) ? to_blk : to_wrap);
  assign ww_end  = ww1 + pad[QW_BITS-1:0];

  always_comb begin
    pstart_next = pstart;
    ww_next     = ww;
    off_next    = off;
    held_next   = held;
    hv_next     = hv;
    push        = 1'b0;
    push_cmd    = '{pstart: pstart, q_first: ww, q_last: ww, data: '0};
    if (accept) begin
      case (opcode)
        OP_START: begin
          pstart_next = start_qw;
          ww_next     = 16'd1;
          off_next    = OFF_W'(1);
          held_next   = '0;
          hv_next     = 1'b0;
          push        = 1'b1;
          push_cmd    = '{pstart: start_qw, q_first: '0, q_last: '0, data: data_word};
        end
        OP_DATA: begin
          if (hv) begin
            ww_next       = ww + 1'b1;
            off_next      = off_inc;
            held_next     = '0;
            hv_next       = 1'b0;
            push          = 1'b1;
            push_cmd.data = {data_word[31:0], held};
          end else begin
            held_next = data_word[31:0];
            hv_next   = 1'b1;
          end
        end
        OP_END: begin
          ww_next         = ww_end;
          off_next        = '0;
          held_next       = '0;
          hv_next         = 1'b0;
          push            = hv || (pad != '0);
          push_cmd.q_last = ww_end - 1'b1;
          push_cmd.data   = hv ? {32'd0, held} : '0;
        end
        default: begin
          // unused opcode: drop the word
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstart <= '0;
      ww     <= '0;
      off    <= '0;
      held   <= '0;
      hv     <= 1'b0;
    end else begin
      pstart <= pstart_next;
      ww     <= ww_next;
      off    <= off_next;
      held   <= held_next;
      hv     <= hv_next;
    end
  end

endmodule

/* hdl/spb_back.sv */
// Back end: walks each command one qword a cycle while not stalled, maps the packet
// index onto the ring and holds the result in the output register. Depends on spb_pkg.
module spb_back #(
  parameter int BLOCK_QWORDS = spb_pkg::DEF_BLOCK_QWORDS,
  parameter int ADDR_BITS    = spb_pkg::DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spb_pkg::cmd_t                 head,
  input  logic                          head_valid,
  output logic                          pop,
  input  logic [spb_pkg::QW_BITS-1:0]   ring_base,
  input  logic [spb_pkg::SIZE_BITS-1:0] ring_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spb_pkg::QW_BITS-1:0]   write_addr,
  output logic                          in_sop,
  output logic [spb_pkg::DATA_BITS-1:0] write_data,
  output logic                          last
);
  import spb_pkg::*;

  localparam logic [QW_BITS-1:0] ADDR_MASK =
    (ADDR_BITS >= QW_BITS) ? {QW_BITS{1'b1}} : QW_BITS'((32'd1 << ADDR_BITS) - 1);

  cmd_t               act;
  logic               act_valid;
  logic [QW_BITS-1:0] act_q;
  logic               act_first;

  logic               can_load;
  logic               act_done;
  logic [16:0]        raw;
  logic [17:0]        ring_end;
  logic               wrapped;
  logic [16:0]        addr_wrap;

  assign can_load = !out_valid || !out_stall;
  assign act_done = (act_q == act.q_last);
  assign pop      = head_valid && (!act_valid || (can_load && act_done));

  assign raw       = {1'b0, act.pstart} + {1'b0, act_q};
  assign ring_end  = {2'b00, ring_base} + {1'b0, ring_size};
  assign wrapped   = ({1'b0, raw} >= ring_end);
  assign addr_wrap = wrapped ? raw - ring_size : raw;

  always_ff @(posedge clk) begin
    if (pop) begin
      act <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      act_q     <= '0;
      act_first <= 1'b0;
    end else if (pop) begin
      act_valid <= 1'b1;
      act_q     <= head.q_first;
      act_first <= 1'b1;
    end else if (act_valid && can_load) begin
      // advance to the next padding qword, or retire the command
      act_valid <= !act_done;
      act_q     <= act_q + 1'b1;
      act_first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= act_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && act_valid) begin
      write_addr <= addr_wrap[QW_BITS-1:0] & ADDR_MASK;
      in_sop     <= !wrapped && (act_q < QW_BITS'(BLOCK_QWORDS));
      write_data <= act_first ? act.data : '0;
      last       <= act_done;
    end
  end

endmodule

/* hdl/spb_checker.sv */
// Port-level checks for the send buffer packer, bound to the top level.
// Depends on spb_pkg for field widths.
module spb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [spb_pkg::QW_BITS-1:0]   write_addr,
  input logic                          in_sop,
  input logic [spb_pkg::DATA_BITS-1:0] write_data,
  input logic                          last
);

  // reset leaves the queue empty and the output register clear
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  // a stalled write holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(write_addr) &&
      $stable(write_data) && $stable(in_sop) && $stable(last))
    else $error("stalled write changed");

  // a run of writes continues without a gap
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap inside a run of writes");

  // only padding follows a non-final write
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> write_data == '0)
    else $error("padding write carries data");

endmodule

bind pio_send_buffer_packer spb_checker u_spb_checker (.*);
